// File: hw/rtl/sgps_pkg.sv
// ----------------------------------------------------------------------------
// sgps_pkg
// Shared types, constants and helpers for the SDF glyph pixel sampler.
// ----------------------------------------------------------------------------
package sgps_pkg;

    // Atlas and palette geometry
    localparam int ATLAS_AW     = 16;
    localparam int ATLAS_DEPTH  = 1 << ATLAS_AW;
    localparam int PAL_AW       = 8;
    localparam int PAL_DEPTH    = 1 << PAL_AW;
    localparam int TEXEL_W      = 16;   // red and green channels only
    localparam int RECIP_W      = 21;   // 16 * 65536 / cell size, up to 2^20
    localparam int SXA_W        = 20;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 13;

    localparam logic [12:0] IMAGE_LIMIT   = 13'd4096;
    localparam logic [9:0]  LEVEL_THRESH  = 10'd381;  // lowest r + 2g whose level still reaches 128
    localparam logic [7:0]  GLYPH_TEXELS  = 8'd16;
    localparam logic [RECIP_W-1:0] RECIP_RESET = 21'd65536;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_CELL_W  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_H  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_W = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_H = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INK     = 3'd4;

    typedef enum logic [1:0] {
        OP_LOAD_ATLAS = 2'd0,
        OP_LOAD_PAL   = 2'd1,
        OP_DRAW       = 2'd2,
        OP_NOP        = 2'd3
    } t_op;

    // Item state carried down the pipeline
    typedef struct packed {
        t_op         op;
        logic        ok;     // draw that passed all clipping checks
        logic [15:0] addr;
        logic [31:0] data;
        logic [11:0] x;
        logic [11:0] y;
        logic [15:0] frx;
        logic [15:0] fry;
    } t_item;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
    } t_texel;

    // One channel of a 16-bit fixed point blend
    function automatic logic [7:0] lerp8(input logic [7:0] c0, input logic [7:0] c1,
                                         input logic [15:0] fr);
        logic [23:0] a;
        logic [23:0] b;
        logic [24:0] s;
        a = 24'(c0) * 24'(16'hFFFF - fr);
        b = 24'(c1) * 24'(fr);
        s = 25'(a) + 25'(b);
        return s[23:16];
    endfunction

endpackage

// File: hw/rtl/sgps_ram.sv
// ----------------------------------------------------------------------------
// sgps_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sgps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/sgps_recip.sv
// ----------------------------------------------------------------------------
// sgps_recip
// Bit-serial divider: 16*65536 / cell size, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sgps_recip
    import sgps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [7:0]         i_divisor,
    output logic               o_busy,
    output logic [RECIP_W-1:0] o_quot
);

    logic               r_busy;
    logic [4:0]         r_cnt;
    logic [7:0]         r_div;
    logic [7:0]         r_rem;
    logic [RECIP_W-1:0] r_quot;

    logic       dividend_bit;
    logic [8:0] shifted;
    logic       ge;
    logic [8:0] diff;

    // Dividend is 2^20: only its top bit is set
    always_comb begin
        dividend_bit = (r_cnt == 5'(RECIP_W - 1));
        shifted      = {r_rem, dividend_bit};
        ge           = (shifted >= {1'b0, r_div});
        diff         = shifted - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_quot <= RECIP_RESET;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 5'(RECIP_W - 1);
            r_quot <= '0;
        end else if (r_busy) begin
            r_quot <= {r_quot[RECIP_W-2:0], ge};
            r_cnt  <= r_cnt - 5'd1;
            if (r_cnt == 5'd0) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Remainder and divisor hold data only
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[7:0] : shifted[7:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

// File: hw/rtl/sdf_glyph_pixel_sampler.sv
// ----------------------------------------------------------------------------
// sdf_glyph_pixel_sampler
// Signed-distance-field glyph sampler with atlas and palette memories.
// ----------------------------------------------------------------------------
// A draw transaction reads the single atlas read port once for each of its four
// bilinear texels; load and no-op transactions and clipped draws use it once.
// Every transaction yields exactly one result, in order. Loads write the
// atlas or palette RAM in pipeline order, so a draw sees every load accepted
// before it. Writing cell_width or cell_height starts a reciprocal
// computation during which no input or configuration transaction is taken.
module sdf_glyph_pixel_sampler
    import sgps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_operation,
    input  logic [15:0]           i_load_address,
    input  logic [31:0]           i_load_data,
    input  logic [15:0]           i_glyph,
    input  logic [7:0]            i_offset_x,
    input  logic [7:0]            i_offset_y,
    input  logic signed [15:0]    i_origin_x,
    input  logic signed [15:0]    i_origin_y,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_write_pixel,
    output logic [11:0]           o_image_x,
    output logic [11:0]           o_image_y,
    output logic [7:0]            o_pixel_color,
    // configuration channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers
    logic [7:0]  r_cell_w, r_cell_h, r_ink;
    logic [12:0] r_img_w, r_img_h;

    logic               busy_x, busy_y;
    logic [RECIP_W-1:0] recip_x, recip_y;
    logic               cfg_acc;

    assign o_cfg_ready = !busy_x && !busy_y;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_w <= GLYPH_TEXELS;
            r_cell_h <= GLYPH_TEXELS;
            r_img_w  <= 13'd256;
            r_img_h  <= 13'd256;
            r_ink    <= 8'd255;
        end else if (cfg_acc) begin
            case (i_cfg_index)
                REG_CELL_W:  r_cell_w <= i_cfg_data[7:0];
                REG_CELL_H:  r_cell_h <= i_cfg_data[7:0];
                REG_IMAGE_W: r_img_w  <= i_cfg_data;
                REG_IMAGE_H: r_img_h  <= i_cfg_data;
                REG_INK:     r_ink    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    sgps_recip u_recip_x (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (cfg_acc && (i_cfg_index == REG_CELL_W)),
        .i_divisor (i_cfg_data[7:0]),
        .o_busy    (busy_x),
        .o_quot    (recip_x)
    );

    sgps_recip u_recip_y (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (cfg_acc && (i_cfg_index == REG_CELL_H)),
        .i_divisor (i_cfg_data[7:0]),
        .o_busy    (busy_y),
        .o_quot    (recip_y)
    );

    // Pipeline control
    logic r_out_v;
    logic adv, up_adv, hold, in_acc;
    logic r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v, r_s6_v, r_s7_v, r_s8_v;
    logic [1:0] r_s4_cnt, r_s5_cnt, r_s6_cnt;
    logic r_s5_last, r_s6_last;

    t_item r_s1, r_s2, r_s3, r_s4, r_s5, r_s6, r_s7, r_s8;

    assign adv        = !r_out_v || i_out_ready;
    assign hold       = r_s4_v && r_s4.ok && (r_s4_cnt != 2'd3);
    assign up_adv     = adv && !hold;
    assign o_in_ready = up_adv && !busy_x && !busy_y;
    assign in_acc     = i_in_valid && o_in_ready;

    // Accept-time clipping checks
    logic [16:0] x_s, y_s;
    logic [12:0] w_lim, h_lim;
    logic        glyph_ok, in_cell, in_img, draw_ok;
    t_item       new_item;

    always_comb begin
        x_s      = {i_origin_x[15], i_origin_x} + {9'b0, i_offset_x};
        y_s      = {i_origin_y[15], i_origin_y} + {9'b0, i_offset_y};
        w_lim    = (r_img_w > IMAGE_LIMIT) ? IMAGE_LIMIT : r_img_w;
        h_lim    = (r_img_h > IMAGE_LIMIT) ? IMAGE_LIMIT : r_img_h;
        glyph_ok = (i_glyph != 16'd0) && (i_glyph[15:8] == 8'd0);
        in_cell  = (i_offset_x < r_cell_w) && (i_offset_y < r_cell_h);
        in_img   = !x_s[16] && (x_s[15:0] < {3'b0, w_lim})
                && !y_s[16] && (y_s[15:0] < {3'b0, h_lim});
        draw_ok  = (t_op'(i_operation) == OP_DRAW) && glyph_ok && in_cell && in_img;

        new_item      = '0;
        new_item.op   = t_op'(i_operation);
        new_item.ok   = draw_ok;
        new_item.addr = i_load_address;
        new_item.data = i_load_data;
        new_item.x    = x_s[11:0];
        new_item.y    = y_s[11:0];
    end

    // Early stage data
    logic [7:0]       r_s1_dx, r_s1_dy, r_s1_glyph;
    logic [SXA_W-1:0] r_s2_sxa, r_s2_sya;
    logic [7:0]       r_s2_glyph;
    logic [15:0]      r_s3_base, r_s3_fx, r_s3_fy;
    logic signed [32:0] r_s3_px, r_s3_py;
    logic [15:0]      r_s4_base;

    logic [28:0] mul_x, mul_y;
    logic [15:0] sx, sy;
    logic signed [32:0] p_x, p_y;
    logic [15:0] frx_c, fry_c;
    t_item       s4_next;

    always_comb begin
        mul_x = 29'(r_s1_dx) * 29'(recip_x);
        mul_y = 29'(r_s1_dy) * 29'(recip_y);
        // sharpening slope cell*cell*256 for cells below 16
        sx    = {8'(r_cell_w[3:0] * r_cell_w[3:0]), 8'b0};
        sy    = {8'(r_cell_h[3:0] * r_cell_h[3:0]), 8'b0};
        // fraction minus one half as a 17-bit signed value
        p_x   = $signed({r_s2_sxa[15], r_s2_sxa[15:0]} ^ 17'h18000) * $signed({1'b0, sx});
        p_y   = $signed({r_s2_sya[15], r_s2_sya[15:0]} ^ 17'h18000) * $signed({1'b0, sy});
        // floor(p / 65536) + 0x8000, kept to 16 bits
        frx_c = (r_cell_w < GLYPH_TEXELS) ? {~r_s3_px[31], r_s3_px[30:16]} : r_s3_fx;
        fry_c = (r_cell_h < GLYPH_TEXELS) ? {~r_s3_py[31], r_s3_py[30:16]} : r_s3_fy;

        s4_next     = r_s3;
        s4_next.frx = frx_c;
        s4_next.fry = fry_c;
    end

    // Front stages: capture, scale multiply, sharpen multiply, issue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_s3_v   <= 1'b0;
            r_s4_v   <= 1'b0;
            r_s4_cnt <= '0;
        end else if (up_adv) begin
            r_s1_v   <= in_acc;
            r_s2_v   <= r_s1_v;
            r_s3_v   <= r_s2_v;
            r_s4_v   <= r_s3_v;
            r_s4_cnt <= '0;
        end else if (adv && hold) begin
            r_s4_cnt <= r_s4_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (up_adv) begin
            r_s1       <= new_item;
            r_s1_dx    <= i_offset_x;
            r_s1_dy    <= i_offset_y;
            r_s1_glyph <= i_glyph[7:0];

            r_s2       <= r_s1;
            r_s2_sxa   <= mul_x[SXA_W-1:0];
            r_s2_sya   <= mul_y[SXA_W-1:0];
            r_s2_glyph <= r_s1_glyph;

            r_s3       <= r_s2;
            r_s3_base  <= {r_s2_glyph[7:4], r_s2_sya[19:16], r_s2_glyph[3:0], r_s2_sxa[19:16]};
            r_s3_fx    <= r_s2_sxa[15:0];
            r_s3_fy    <= r_s2_sya[15:0];
            r_s3_px    <= p_x;
            r_s3_py    <= p_y;

            r_s4       <= s4_next;
            r_s4_base  <= r_s3_base;
        end
    end

    // Atlas RAM: four texel reads per draw, atlas loads write here
    logic [ATLAS_AW-1:0] atlas_raddr;
    logic [7:0]          atlas_rdata;

    assign atlas_raddr = r_s4_base + {7'b0, r_s4_cnt[1], 7'b0, r_s4_cnt[0]};

    sgps_ram #(.WIDTH(8), .DEPTH(ATLAS_DEPTH)) u_atlas (
        .i_clk   (i_clk),
        .i_we    (adv && r_s4_v && (r_s4.op == OP_LOAD_ATLAS)),
        .i_waddr (r_s4.addr),
        .i_wdata (r_s4.data[7:0]),
        .i_re    (adv),
        .i_raddr (atlas_raddr),
        .o_rdata (atlas_rdata)
    );

    // Palette RAM: keeps red and green only; palette loads write here
    t_texel pal_rdata;
    t_texel pal_wdata;

    assign pal_wdata = '{r: r_s5.data[23:16], g: r_s5.data[15:8]};

    sgps_ram #(.WIDTH(TEXEL_W), .DEPTH(PAL_DEPTH)) u_palette (
        .i_clk   (i_clk),
        .i_we    (adv && r_s5_v && (r_s5.op == OP_LOAD_PAL) && (r_s5.addr[15:8] == 8'd0)),
        .i_waddr (r_s5.addr[PAL_AW-1:0]),
        .i_wdata (pal_wdata),
        .i_re    (adv),
        .i_raddr (atlas_rdata),
        .o_rdata (pal_rdata)
    );

    // Back stages valid tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_v  <= 1'b0;
            r_s6_v  <= 1'b0;
            r_s7_v  <= 1'b0;
            r_s8_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_s5_v  <= r_s4_v;
            r_s6_v  <= r_s5_v;
            r_s7_v  <= r_s6_v && r_s6_last;
            r_s8_v  <= r_s7_v;
            r_out_v <= r_s8_v;
        end
    end

    // Texel collection, horizontal and vertical blends
    t_texel r_tex0, r_tex1, r_tex2;
    t_texel r_t0, r_t1, r_t2, r_t3;
    logic [7:0] r_top_r, r_top_g, r_bot_r, r_bot_g;
    logic [7:0] v_r, v_g;
    logic [9:0] lvl_sum;
    logic       pass;

    always_comb begin
        v_r     = lerp8(r_top_r, r_bot_r, r_s8.fry);
        v_g     = lerp8(r_top_g, r_bot_g, r_s8.fry);
        lvl_sum = {2'b0, v_r} + {1'b0, v_g, 1'b0};
        pass    = r_s8.ok && (lvl_sum >= LEVEL_THRESH);
    end

    logic        r_out_write;
    logic [11:0] r_out_x, r_out_y;
    logic [7:0]  r_out_color;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s5      <= r_s4;
            r_s5_cnt  <= r_s4_cnt;
            r_s5_last <= !hold;

            r_s6      <= r_s5;
            r_s6_cnt  <= r_s5_cnt;
            r_s6_last <= r_s5_last;

            if (r_s6_v && !r_s6_last) begin
                case (r_s6_cnt)
                    2'd0:    r_tex0 <= pal_rdata;
                    2'd1:    r_tex1 <= pal_rdata;
                    default: r_tex2 <= pal_rdata;
                endcase
            end

            r_s7 <= r_s6;
            r_t0 <= r_tex0;
            r_t1 <= r_tex1;
            r_t2 <= r_tex2;
            r_t3 <= pal_rdata;

            r_s8    <= r_s7;
            r_top_r <= lerp8(r_t0.r, r_t1.r, r_s7.frx);
            r_top_g <= lerp8(r_t0.g, r_t1.g, r_s7.frx);
            r_bot_r <= lerp8(r_t2.r, r_t3.r, r_s7.frx);
            r_bot_g <= lerp8(r_t2.g, r_t3.g, r_s7.frx);

            r_out_write <= pass;
            r_out_x     <= pass ? r_s8.x : 12'd0;
            r_out_y     <= pass ? r_s8.y : 12'd0;
            r_out_color <= pass ? r_ink : 8'd0;
        end
    end

    assign o_out_valid   = r_out_v;
    assign o_write_pixel = r_out_write;
    assign o_image_x     = r_out_x;
    assign o_image_y     = r_out_y;
    assign o_pixel_color = r_out_color;

endmodule

// File: hw/rtl/sgps_checker.sv
// ----------------------------------------------------------------------------
// sgps_checker
// Port-level assertions for the SDF glyph pixel sampler, bound to the top.
// ----------------------------------------------------------------------------
module sgps_checker
    import sgps_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic                  o_write_pixel,
    input logic [11:0]           o_image_x,
    input logic [11:0]           o_image_y,
    input logic [7:0]            o_pixel_color,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [CFG_IDX_W-1:0]  i_cfg_index
);

    // No result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A result without ink carries zero fields
    a_no_ink_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_write_pixel |->
            (o_image_x == 12'd0) && (o_image_y == 12'd0) && (o_pixel_color == 8'd0))
        else $error("non-ink result with nonzero fields");

    // A cell size write blocks input while the reciprocal is computed
    a_cell_write_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready
            && ((i_cfg_index == REG_CELL_W) || (i_cfg_index == REG_CELL_H))
            |=> !o_in_ready && !o_cfg_ready)
        else $error("input taken during reciprocal computation");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_write_pixel) && $stable(o_image_x)
            && $stable(o_image_y) && $stable(o_pixel_color))
        else $error("stalled result changed");

endmodule

bind sdf_glyph_pixel_sampler sgps_checker u_sgps_checker (.*);

// File: tb/sdf_glyph_pixel_sampler_chk.sv
// ----------------------------------------------------------------------------
// sdf_glyph_pixel_sampler_chk
// Watches the input, output and register channels of the glyph sampler,
// keeps a shadow atlas, palette and register set, predicts the ink write of
// every input transaction and compares each output transaction in order.
// ----------------------------------------------------------------------------
module sdf_glyph_pixel_sampler_chk
    import sgps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [1:0]            i_operation,
    input  logic [15:0]           i_load_address,
    input  logic [31:0]           i_load_data,
    input  logic [15:0]           i_glyph,
    input  logic [7:0]            i_offset_x,
    input  logic [7:0]            i_offset_y,
    input  logic signed [15:0]    i_origin_x,
    input  logic signed [15:0]    i_origin_y,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic                  i_write_pixel,
    input  logic [11:0]           i_image_x,
    input  logic [11:0]           i_image_y,
    input  logic [7:0]            i_pixel_color,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_inks
);

    typedef struct packed {
        logic        wr;
        logic [11:0] x;
        logic [11:0] y;
        logic [7:0]  color;
    } ink_write_t;

    localparam int IMG_CLAMP = 4096;
    localparam int FRAC_ONE  = 65536;
    localparam int FRAC_HALF = 32768;
    localparam int CELL_TEX  = 16;

    logic [7:0]  atlas_mem [ATLAS_DEPTH];
    logic [31:0] pal_mem [PAL_DEPTH];
    logic [7:0]  cell_w, cell_h, ink;
    logic [12:0] img_w, img_h;
    ink_write_t  expected_writes[$];

    // palette color of one atlas texel, address wraps at 64K
    function automatic logic [31:0] texel_color(input int unsigned addr);
        return pal_mem[atlas_mem[addr & 32'hFFFF]];
    endfunction

    // per-channel 16-bit fixed point blend
    function automatic logic [31:0] blend(input logic [31:0] a, input logic [31:0] b,
                                          input int unsigned fr);
        logic [31:0] res;
        int unsigned c;
        res = '0;
        for (int sh = 0; sh < 32; sh += 8) begin
            c = (int'(a[sh+:8]) * (32'hFFFF - fr) + int'(b[sh+:8]) * fr) >> 16;
            res[sh+:8] = c[7:0];
        end
        return res;
    endfunction

    // pull the fraction toward one half for cells below the glyph size
    function automatic int unsigned sharpen_frac(input int unsigned f, input logic [7:0] size);
        longint s;
        longint p;
        longint q;
        s = (size < CELL_TEX) ? (longint'(size) * size * FRAC_ONE) / 256 : FRAC_ONE;
        p = (longint'(f) - FRAC_HALF) * s;
        q = (p >= 0) ? p / FRAC_ONE : -((-p + FRAC_ONE - 1) / FRAC_ONE);
        return int'((q + FRAC_HALF) & 32'hFFFF);
    endfunction

    function automatic ink_write_t predict_draw(input logic [15:0] glyph,
                                                input logic [7:0] dx, input logic [7:0] dy,
                                                input logic signed [15:0] ox,
                                                input logic signed [15:0] oy);
        ink_write_t  res;
        int          x, y, w, h, r, g, s, q;
        int unsigned sxa, sya, sxb, syb, frx, fry, base;
        logic [31:0] px;
        res = '0;
        if (glyph == 0 || glyph >= 256) return res;
        if (dx >= cell_w || dy >= cell_h) return res;
        x = int'(ox) + int'(dx);
        y = int'(oy) + int'(dy);
        w = (img_w > IMG_CLAMP) ? IMG_CLAMP : int'(img_w);
        h = (img_h > IMG_CLAMP) ? IMG_CLAMP : int'(img_h);
        if (x < 0 || x >= w || y < 0 || y >= h) return res;
        sxa = dx * ((CELL_TEX * FRAC_ONE) / cell_w);
        sya = dy * ((CELL_TEX * FRAC_ONE) / cell_h);
        sxb = glyph[3:0] * CELL_TEX + (sxa >> 16);
        syb = glyph[7:4] * CELL_TEX + (sya >> 16);
        frx = sharpen_frac(sxa & 32'hFFFF, cell_w);
        fry = sharpen_frac(sya & 32'hFFFF, cell_h);
        base = syb * 256 + sxb;
        px = blend(blend(texel_color(base), texel_color(base + 1), frx),
                   blend(texel_color(base + 256), texel_color(base + 257), frx), fry);
        r = px[23:16];
        g = px[15:8];
        s = (r - 128) + 2 * (g - 128);
        q = (s >= 0) ? s / 4 : -((-s) / 4);
        if (q + 128 >= 128) begin
            res.wr    = 1'b1;
            res.x     = x[11:0];
            res.y     = y[11:0];
            res.color = ink;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, exp_val, $realtime);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        ink_write_t got, want;
        if (!i_rst_n) begin
            cell_w   = 8'd16;
            cell_h   = 8'd16;
            img_w    = 13'd256;
            img_h    = 13'd256;
            ink      = 8'd255;
            expected_writes.delete();
            o_errors = 0;
            o_inks   = 0;
        end else begin
            // register write transaction
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_CELL_W:  cell_w = i_cfg_data[7:0];
                    REG_CELL_H:  cell_h = i_cfg_data[7:0];
                    REG_IMAGE_W: img_w  = i_cfg_data;
                    REG_IMAGE_H: img_h  = i_cfg_data;
                    REG_INK:     ink    = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            // result transaction against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                got = {i_write_pixel, i_image_x, i_image_y, i_pixel_color};
                if (expected_writes.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = expected_writes.pop_front();
                    if (got.wr != want.wr) report_mismatch("write_pixel", got.wr, want.wr);
                    if (got.x != want.x) report_mismatch("image_x", got.x, want.x);
                    if (got.y != want.y) report_mismatch("image_y", got.y, want.y);
                    if (got.color != want.color)
                        report_mismatch("pixel_color", got.color, want.color);
                    if (want.wr) o_inks++;
                end
            end
            // input transaction
            if (i_in_valid && i_in_ready) begin
                want = '0;
                case (t_op'(i_operation))
                    OP_LOAD_ATLAS: atlas_mem[i_load_address] = i_load_data[7:0];
                    OP_LOAD_PAL: begin
                        if (i_load_address < PAL_DEPTH) pal_mem[i_load_address[7:0]] = i_load_data;
                    end
                    OP_DRAW: want = predict_draw(i_glyph, i_offset_x, i_offset_y,
                                                 i_origin_x, i_origin_y);
                    default: ;
                endcase
                expected_writes.push_back(want);
            end
        end
        o_pending = expected_writes.size();
    end

endmodule

// File: tb/sdf_glyph_pixel_sampler_tb.sv
// ----------------------------------------------------------------------------
// sdf_glyph_pixel_sampler_tb
// Fills the atlas cells of the two drawn glyphs and the whole palette, runs
// directed draws and loads, then random traffic under several register
// settings and idle/stall patterns.
// The checker module predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module sdf_glyph_pixel_sampler_tb;
    import sgps_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int ITEMS_PER_PHASE = 125;
    // glyphs whose atlas cells are loaded; the second one wraps the atlas
    localparam logic [15:0] GLYPH_A = 16'd1;
    localparam logic [15:0] GLYPH_B = 16'd255;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  o_in_ready;
    logic [1:0]            operation = '0;
    logic [15:0]           load_address = '0;
    logic [31:0]           load_data = '0;
    logic [15:0]           glyph = '0;
    logic [7:0]            offset_x = '0;
    logic [7:0]            offset_y = '0;
    logic signed [15:0]    origin_x = '0;
    logic signed [15:0]    origin_y = '0;
    logic                  o_out_valid;
    logic                  out_ready = 1'b0;
    logic                  o_write_pixel;
    logic [11:0]           o_image_x;
    logic [11:0]           o_image_y;
    logic [7:0]            o_pixel_color;
    logic                  cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int errors, pending, inks;
    int cycles = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int n_items = 0;
    int n_draws = 0;
    int n_regs = 0;
    int cw = 16, ch = 16, iw = 256, ih = 256;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    sdf_glyph_pixel_sampler i_dut (
        .i_clk, .i_rst_n,
        .i_in_valid(in_valid), .o_in_ready,
        .i_operation(operation), .i_load_address(load_address), .i_load_data(load_data),
        .i_glyph(glyph), .i_offset_x(offset_x), .i_offset_y(offset_y),
        .i_origin_x(origin_x), .i_origin_y(origin_y),
        .o_out_valid, .i_out_ready(out_ready),
        .o_write_pixel, .o_image_x, .o_image_y, .o_pixel_color,
        .i_cfg_valid(cfg_valid), .o_cfg_ready,
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    sdf_glyph_pixel_sampler_chk i_chk (
        .i_clk, .i_rst_n,
        .i_in_valid(in_valid), .i_in_ready(o_in_ready),
        .i_operation(operation), .i_load_address(load_address), .i_load_data(load_data),
        .i_glyph(glyph), .i_offset_x(offset_x), .i_offset_y(offset_y),
        .i_origin_x(origin_x), .i_origin_y(origin_y),
        .i_out_valid(o_out_valid), .i_out_ready(out_ready),
        .i_write_pixel(o_write_pixel), .i_image_x(o_image_x), .i_image_y(o_image_y),
        .i_pixel_color(o_pixel_color),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending), .o_inks(inks)
    );

    // result side back-pressure
    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // 0 none, 1 sender idle, 2 receiver stall, 3 both
    task automatic set_idling(input int mode);
        idle_pct  = (mode == 1) ? 57 : (mode == 3) ? 13 : 0;
        stall_pct = (mode == 2) ? 57 : (mode == 3) ? 13 : 0;
    endtask

    // one input transaction; valid stays up until accepted
    task automatic send_item(input t_op op, input logic [15:0] addr, input logic [31:0] data,
                             input logic [15:0] gl, input logic [7:0] dx, input logic [7:0] dy,
                             input logic signed [15:0] ox, input logic signed [15:0] oy);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        load_address <= addr;
        load_data    <= data;
        glyph        <= gl;
        offset_x     <= dx;
        offset_y     <= dy;
        origin_x     <= ox;
        origin_y     <= oy;
        do @(posedge i_clk); while (!o_in_ready);
        n_items++;
        if (op == OP_DRAW) n_draws++;
    endtask

    task automatic draw(input logic [15:0] gl, input logic [7:0] dx, input logic [7:0] dy,
                        input logic signed [15:0] ox, input logic signed [15:0] oy);
        send_item(OP_DRAW, 16'($urandom), $urandom, gl, dx, dy, ox, oy);
    endtask

    // load every atlas texel that a draw of this glyph can touch (17 x 17)
    task automatic fill_glyph(input logic [15:0] gl);
        for (int r = 0; r <= 16; r++)
            for (int c = 0; c <= 16; c++)
                send_item(OP_LOAD_ATLAS,
                          16'((int'(gl[7:4]) * 16 + r) * 256 + int'(gl[3:0]) * 16 + c),
                          $urandom, 16'($urandom), 8'($urandom), 8'($urandom),
                          16'($urandom), 16'($urandom));
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
        n_regs++;
    endtask

    task automatic apply_setting(input int w, input int h, input int imw, input int imh,
                                 input int ink_idx);
        drain();
        write_reg(REG_CELL_W, w);
        write_reg(REG_CELL_H, h);
        write_reg(REG_IMAGE_W, imw);
        write_reg(REG_IMAGE_H, imh);
        write_reg(REG_INK, ink_idx);
        cw = w; ch = h; iw = imw; ih = imh;
    endtask

    // mostly in-cell, on-image draws with random content; some loads and noise
    task automatic random_item();
        int          pick, weff, heff;
        logic [7:0]  dx, dy;
        logic [15:0] gl;
        logic signed [15:0] ox, oy;
        pick = $urandom_range(99);
        if (pick < 8) begin
            send_item(OP_LOAD_ATLAS, 16'($urandom), $urandom, 16'($urandom), 8'($urandom),
                      8'($urandom), 16'($urandom), 16'($urandom));
        end else if (pick < 14) begin
            send_item(OP_LOAD_PAL, ($urandom_range(9) == 0) ? 16'($urandom)
                      : 16'($urandom_range(255)), $urandom, 16'($urandom), 8'($urandom),
                      8'($urandom), 16'($urandom), 16'($urandom));
        end else if (pick < 17) begin
            send_item(OP_NOP, 16'($urandom), $urandom, 16'($urandom), 8'($urandom),
                      8'($urandom), 16'($urandom), 16'($urandom));
        end else begin
            weff = (iw > 4096) ? 4096 : iw;
            heff = (ih > 4096) ? 4096 : ih;
            dx = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(cw - 1));
            dy = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(ch - 1));
            // loaded glyphs, now and then a code that draws nothing
            if ($urandom_range(19) == 0)
                gl = ($urandom_range(1) == 0) ? 16'd0 : 16'($urandom_range(65535, 256));
            else
                gl = ($urandom_range(1) == 0) ? GLYPH_A : GLYPH_B;
            ox = ($urandom_range(9) == 0) ? 16'($urandom)
                 : 16'(int'($urandom_range(weff - 1)) - int'(dx) + int'($urandom_range(4)) - 2);
            oy = ($urandom_range(9) == 0) ? 16'($urandom)
                 : 16'(int'($urandom_range(heff - 1)) - int'(dy) + int'($urandom_range(4)) - 2);
            draw(gl, dx, dy, ox, oy);
        end
    endtask

    initial begin
        int settings [6][5];
        settings = '{'{1, 1, 1, 1, 0}, '{255, 255, 4096, 4096, 170}, '{8, 12, 300, 200, 7},
                     '{5, 20, 8191, 100, 90}, '{24, 3, 640, 8191, 33},
                     '{16, 16, 256, 256, 255}};
        set_idling(0);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill the drawn glyph cells and the palette so no draw reads an unwritten entry
        fill_glyph(GLYPH_A);
        fill_glyph(GLYPH_B);
        for (int p = 0; p < PAL_DEPTH; p++)
            send_item(OP_LOAD_PAL, 16'(p), $urandom, 16'($urandom), 8'($urandom),
                      8'($urandom), 16'($urandom), 16'($urandom));

        // directed: field extremes, ignored loads, no-op, rejected and clipped draws
        send_item(OP_LOAD_ATLAS, 16'h0000, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 8'hFF,
                  16'sh7FFF, 16'sh7FFF);
        send_item(OP_LOAD_ATLAS, 16'hFFFF, 32'h1234_5600, 16'h0000, 8'h00, 8'h00,
                  -16'sd32768, -16'sd32768);
        send_item(OP_LOAD_PAL, 16'd255, 32'hFFFF_FFFF, 16'd0, 8'd0, 8'd0, 16'sd0, 16'sd0);
        send_item(OP_LOAD_PAL, 16'd256, 32'h0000_0000, 16'd0, 8'd0, 8'd0, 16'sd0, 16'sd0);
        send_item(OP_LOAD_PAL, 16'hFFFF, $urandom, 16'd0, 8'd0, 8'd0, 16'sd0, 16'sd0);
        send_item(OP_NOP, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 8'hFF, -16'sd1, -16'sd1);
        draw(16'd0, 8'd3, 8'd3, 16'sd10, 16'sd10);
        draw(16'd256, 8'd3, 8'd3, 16'sd10, 16'sd10);
        draw(16'hFFFF, 8'd3, 8'd3, 16'sd10, 16'sd10);
        draw(GLYPH_B, 8'd15, 8'd15, 16'sd0, 16'sd0);
        draw(GLYPH_A, 8'd0, 8'd0, 16'sd0, 16'sd0);
        draw(16'd65, 8'd16, 8'd2, 16'sd20, 16'sd20);
        draw(16'd65, 8'd2, 8'd16, 16'sd20, 16'sd20);
        draw(16'd66, 8'd5, 8'd5, -16'sd32768, -16'sd32768);
        draw(16'd66, 8'd5, 8'd5, 16'sh7FFF, 16'sh7FFF);
        draw(GLYPH_A, 8'd15, 8'd7, 16'sd240, 16'sd40);
        draw(GLYPH_A, 8'd15, 8'd7, 16'sd241, 16'sd40);
        draw(16'd98, 8'd4, 8'd0, 16'sd4, -16'sd1);
        draw(GLYPH_B, 8'd15, 8'd15, 16'sd240, 16'sd240);
        for (int k = 0; k < 6; k++)
            draw(($urandom_range(1) == 0) ? GLYPH_A : GLYPH_B, 8'($urandom_range(15)),
                 8'($urandom_range(15)), 16'($urandom_range(200)), 16'($urandom_range(200)));

        // random phases, each under its own register setting
        for (int ph = 0; ph < 6; ph++) begin
            apply_setting(settings[ph][0], settings[ph][1], settings[ph][2], settings[ph][3],
                          settings[ph][4]);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                set_idling((k / 60 + ph) % 4);
                if (k == 62) drain();
                random_item();
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        $display("Run: %0d input transactions (%0d draws), %0d register writes,", n_items,
                 n_draws, n_regs);
        $display("     %0d ink writes checked over 7 register settings.", inks);
        if (errors == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
